/* rtl/dqe_pkg.sv */
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants for the array deque engine: sizes, operation
// and status codes, and the command bundle sent to the element store.
// ----------------------------------------------------------------------------
package dqe_pkg;

   // Store geometry
   localparam int DEPTH   = 128;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;

   // Payload field widths
   localparam int OP_W     = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 4'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 4'd5;
   localparam logic [OP_W-1:0] OP_SIZE       = 4'd6;
   localparam logic [OP_W-1:0] OP_EMPTY      = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;
   localparam logic [OP_W-1:0] OP_REVERSE    = 4'd9;
   localparam logic [OP_W-1:0] OP_SORT       = 4'd10;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // Index of the last slot
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   // One cycle of store traffic: one write port, one read port
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } store_cmd_type;

endpackage

/* rtl/dqe_req_if.sv */
// ----------------------------------------------------------------------------
// dqe_req_if
// Request channel: valid/ready handshake carrying an operation and a value.
// ----------------------------------------------------------------------------
interface dqe_req_if
   import dqe_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);

endinterface

/* rtl/dqe_rsp_if.sv */
// ----------------------------------------------------------------------------
// dqe_rsp_if
// Response channel: valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface dqe_rsp_if
   import dqe_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] read_value;
   logic [COUNT_W-1:0]       count;
   logic                     is_empty;

   modport source (output valid, output status, output read_value, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input count,
                   input is_empty, output ready);

endinterface

/* rtl/dqe_store.sv */
// ----------------------------------------------------------------------------
// dqe_store
// Element store: DEPTH signed words, one write and one registered read per
// cycle. A read of the address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
module dqe_store
   import dqe_pkg::*;
   (
   input  logic                     clock,
   input  store_cmd_type            cmd,
   output logic signed [DATA_W-1:0] rd_data
   );

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dqe_ctrl.sv */
// ----------------------------------------------------------------------------
// dqe_ctrl
// Sequencer and datapath: keeps head/tail/occupied, decodes requests, drives
// the store, and walks it for reverse, and through one signed compare unit for sort.
// ----------------------------------------------------------------------------
module dqe_ctrl
   import dqe_pkg::*;
   (
   input  logic                     clock,
   input  logic                     reset,
   dqe_req_if.sink                  req,
   dqe_rsp_if.source                rsp,
   output store_cmd_type            cmd,
   input  logic signed [DATA_W-1:0] rd_data
   );

   // Sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_REV_RI  = 4'd1;
   localparam logic [3:0] S_REV_RJ  = 4'd2;
   localparam logic [3:0] S_REV_WI  = 4'd3;
   localparam logic [3:0] S_REV_WJ  = 4'd4;
   localparam logic [3:0] S_SORT_I  = 4'd5;
   localparam logic [3:0] S_SORT_A  = 4'd6;
   localparam logic [3:0] S_SORT_C  = 4'd7;
   localparam logic [3:0] S_SORT_WI = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic                     occ_ff, occ_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic signed [DATA_W-1:0] a_ff, a_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     sel_rd_ff, sel_rd_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     accept;
   logic                     held_greater;
   logic [CNT_W-1:0]         cnt;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;

   // Compare unit: held element against the word just read
   assign held_greater = a_ff > rd_data;

   // Element count; head/tail are stable while a response waits
   assign cnt = occ_ff ? (CNT_W'(tail_ff) - CNT_W'(head_ff) + CNT_W'(1)) : '0;

   // Response payload
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.read_value = sel_rd_ff ? rd_data : '0;
   assign rsp.count      = COUNT_W'(cnt);
   assign rsp.is_empty   = !occ_ff;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      status_in    = status_ff;
      sel_rd_in    = sel_rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in    = ST_OK;
               sel_rd_in    = 1'b0;
               rsp_valid_in = 1'b1;
               unique case (req.op) inside
                  OP_PUSH_FRONT: begin
                     if (!occ_ff || head_ff == '0) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        head_in     = head_ff - IDX_W'(1);
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = head_ff - IDX_W'(1);
                        cmd.wr_data = req.push_value;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (occ_ff && tail_ff == LAST_SLOT) begin
                        status_in = ST_OVERFLOW;
                     end else if (!occ_ff) begin
                        head_in     = '0;
                        tail_in     = '0;
                        occ_in      = 1'b1;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = '0;
                        cmd.wr_data = req.push_value;
                     end else begin
                        tail_in     = tail_ff + IDX_W'(1);
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = tail_ff + IDX_W'(1);
                        cmd.wr_data = req.push_value;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (!occ_ff) begin
                        status_in = ST_EMPTY;
                     end else begin
                        sel_rd_in   = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = (req.op == OP_POP_FRONT) ? head_ff : tail_ff;
                        if (head_ff == tail_ff) begin
                           occ_in  = 1'b0;
                           head_in = '0;
                           tail_in = '0;
                        end else if (req.op == OP_POP_FRONT) begin
                           head_in = head_ff + IDX_W'(1);
                        end else begin
                           tail_in = tail_ff - IDX_W'(1);
                        end
                     end
                  end
                  OP_PEEK_FRONT, OP_PEEK_BACK: begin
                     if (!occ_ff) begin
                        status_in = ST_EMPTY;
                     end else begin
                        sel_rd_in   = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = (req.op == OP_PEEK_FRONT) ? head_ff : tail_ff;
                     end
                  end
                  OP_CLEAR: begin
                     occ_in  = 1'b0;
                     head_in = '0;
                     tail_in = '0;
                  end
                  OP_REVERSE: begin
                     if (occ_ff && head_ff < tail_ff) begin
                        rsp_valid_in = 1'b0;
                        i_in         = head_ff;
                        j_in         = tail_ff;
                        state_in     = S_REV_RI;
                     end
                  end
                  OP_SORT: begin
                     if (occ_ff && head_ff < tail_ff) begin
                        rsp_valid_in = 1'b0;
                        i_in         = head_ff;
                        state_in     = S_SORT_I;
                     end
                  end
                  default: begin
                     // size, empty and unused codes only report
                  end
               endcase
            end
         end

         // Reverse: read both ends, write them back crossed
         S_REV_RI: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff;
            state_in    = S_REV_RJ;
         end
         S_REV_RJ: begin
            a_in        = rd_data;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff;
            state_in    = S_REV_WI;
         end
         S_REV_WI: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_data = rd_data;
            state_in    = S_REV_WJ;
         end
         S_REV_WJ: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff;
            cmd.wr_data = a_ff;
            i_in        = i_ff + IDX_W'(1);
            j_in        = j_ff - IDX_W'(1);
            state_in    = ((i_ff + IDX_W'(1)) < (j_ff - IDX_W'(1))) ? S_REV_RI : S_FIN;
         end

         // Sort: hold slot i, sweep j over the rest, keep the smaller value
         S_SORT_I: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff;
            j_in        = i_ff + IDX_W'(1);
            state_in    = S_SORT_A;
         end
         S_SORT_A: begin
            a_in        = rd_data;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff;
            state_in    = S_SORT_C;
         end
         S_SORT_C: begin
            if (held_greater) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = j_ff;
               cmd.wr_data = a_ff;
               a_in        = rd_data;
            end
            if (j_ff == tail_ff) begin
               state_in = S_SORT_WI;
            end else begin
               j_in        = j_ff + IDX_W'(1);
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = j_ff + IDX_W'(1);
            end
         end
         S_SORT_WI: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_data = a_ff;
            i_in        = i_ff + IDX_W'(1);
            state_in    = ((i_ff + IDX_W'(1)) < tail_ff) ? S_SORT_I : S_FIN;
         end

         S_FIN: begin
            status_in    = ST_OK;
            sel_rd_in    = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      a_ff      <= a_in;
      status_ff <= status_in;
      sel_rd_ff <= sel_rd_in;
   end

endmodule

/* rtl/array_deque_engine.sv */
// ----------------------------------------------------------------------------
// array_deque_engine
// Double-ended queue in a linear array of DEPTH signed words, with push/pop/
// peek at both ends, size, empty, clear, in-place reverse and signed sort.
// ----------------------------------------------------------------------------
// One request is worked at a time and yields one response. Pushes, pops and
// peeks do their single store access in the accept cycle; size, empty, clear
// and unused codes need none. All present the response on the next cycle,
// and no new request is taken until that response has been taken. Reverse
// reads both ends of each pair on the one store read port, then writes them
// back crossed, and responds once all pairs are swapped. Sort is an exchange
// sort through one signed compare unit: for each held slot i it sweeps every
// later element, swapping the held value for any smaller one, then writes the
// held value back to slot i. The store needs no clearing pass after reset;
// push back onto an empty queue restarts at slot zero, and push front only
// refills slots freed by earlier front pops.
// ----------------------------------------------------------------------------
module array_deque_engine
   import dqe_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   dqe_req_if.sink   req_ch,
   dqe_rsp_if.source rsp_ch
   );

   store_cmd_type            store_cmd;
   logic signed [DATA_W-1:0] store_rd_data;

   // Sequencer and compare datapath
   dqe_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .cmd     (store_cmd),
      .rd_data (store_rd_data)
   );

   // Element store
   dqe_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (store_rd_data)
   );

endmodule
